// ===== sv/drt_pkg.sv =====
`default_nettype none

package drt_pkg;

    // Item kinds carried on tuser
    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_WHOLE = 2'd1;
    localparam logic [1:0] KIND_DRAIN = 2'd2;

    // Configuration register indexes
    localparam int         CFG_IDX_W   = 1;
    localparam int         CFG_DATA_W  = 15;
    localparam logic [CFG_IDX_W-1:0] CFG_SURF_W = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SURF_H = 1'd1;

    localparam int RECT_W = 64;

    // Store write data selects
    typedef logic [1:0] t_wsel;
    localparam t_wsel WSEL_ITEM  = 2'd0;
    localparam t_wsel WSEL_WHOLE = 2'd1;
    localparam t_wsel WSEL_MERGE = 2'd2;

    // Left edge in the lowest bits, bottom edge in the highest
    typedef struct packed {
        logic signed [15:0] bottom;
        logic signed [15:0] right;
        logic signed [15:0] top;
        logic signed [15:0] left;
    } t_rect;

    typedef struct packed {
        logic  ren;
        logic  wen;
        t_wsel wsel;
        logic  ld_item;
        logic  ld_out;
        logic  out_last;
    } t_drt_cmd;

    typedef struct packed {
        logic hit;
        logic out_free;
    } t_drt_sts;

    function automatic logic f_empty(input t_rect a);
        f_empty = (a.right <= a.left) || (a.bottom <= a.top);
    endfunction

    // s fully contains n
    function automatic logic f_contains(input t_rect s, input t_rect n);
        f_contains = (s.left <= n.left) && (n.right <= s.right) &&
                     (s.top <= n.top) && (n.bottom <= s.bottom);
    endfunction

    function automatic t_rect f_merge(input t_rect last, input t_rect n);
        t_rect u;
        logic  le;
        logic  ne;
        le = f_empty(last);
        ne = f_empty(n);
        u  = last;
        if (le) begin
            if (!ne) begin
                u = n;
            end
        end else if (!ne) begin
            if (n.left < last.left)     u.left   = n.left;
            if (n.top < last.top)       u.top    = n.top;
            if (n.right > last.right)   u.right  = n.right;
            if (n.bottom > last.bottom) u.bottom = n.bottom;
        end
        f_merge = u;
    endfunction

endpackage

`default_nettype wire

// ===== sv/drt_dp.sv =====
`default_nettype none

module drt_dp
    import drt_pkg::*;
#(
    parameter int MAX_RECTS = 16,
    parameter int IDX_W     = 4
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_we,
    input  wire [CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire [CFG_DATA_W-1:0]   i_cfg_wdata,
    input  wire [RECT_W-1:0]       i_item,
    input  wire t_drt_cmd          i_cmd,
    input  wire [IDX_W-1:0]        i_raddr,
    input  wire [IDX_W-1:0]        i_waddr,
    output t_drt_sts               o_sts,
    input  wire                    i_out_ready,
    output logic                   o_out_valid,
    output logic [RECT_W-1:0]      o_out_data,
    output logic                   o_out_last
);

    logic [RECT_W-1:0]     r_mem [MAX_RECTS];
    logic [RECT_W-1:0]     r_rd;
    t_rect                 r_item;
    logic [CFG_DATA_W-1:0] r_surf_w;
    logic [CFG_DATA_W-1:0] r_surf_h;
    logic                  r_out_vld;
    logic [RECT_W-1:0]     r_out_data;
    logic                  r_out_last;
    t_rect                 n_wdata;
    t_rect                 w_whole;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_surf_w <= '0;
            r_surf_h <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SURF_W: r_surf_w <= i_cfg_wdata;
                CFG_SURF_H: r_surf_h <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_item) begin
            r_item <= t_rect'(i_item);
        end
    end

    always_comb begin
        w_whole.left   = '0;
        w_whole.top    = '0;
        w_whole.right  = {1'b0, r_surf_w};
        w_whole.bottom = {1'b0, r_surf_h};
        case (i_cmd.wsel)
            WSEL_ITEM:  n_wdata = r_item;
            WSEL_WHOLE: n_wdata = w_whole;
            WSEL_MERGE: n_wdata = f_merge(t_rect'(r_rd), r_item);
            default:    n_wdata = r_item;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wen) begin
            r_mem[i_waddr] <= n_wdata;
        end
        if (i_cmd.ren) begin
            r_rd <= r_mem[i_raddr];
        end
    end

    // Output register: load from the read stage, drop on a taken beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.ld_out) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_out) begin
            r_out_data <= r_rd;
            r_out_last <= i_cmd.out_last;
        end
    end

    assign o_sts.hit      = f_contains(t_rect'(r_rd), r_item);
    assign o_sts.out_free = !r_out_vld || i_out_ready;
    assign o_out_valid    = r_out_vld;
    assign o_out_data     = r_out_data;
    assign o_out_last     = r_out_last;

endmodule

`default_nettype wire

// ===== sv/drt_ctrl.sv =====
`default_nettype none

module drt_ctrl
    import drt_pkg::*;
#(
    parameter int MAX_RECTS = 16,
    parameter int IDX_W     = 4,
    parameter int CNT_W     = 5
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    input  wire [1:0]        i_kind,
    output logic             o_in_ready,
    input  wire t_drt_sts    i_sts,
    output t_drt_cmd         o_cmd,
    output logic [IDX_W-1:0] o_raddr,
    output logic [IDX_W-1:0] o_waddr
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_RECTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_RECTS - 1);

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic             r_rd_vld, n_rd_vld;
    logic             r_rd_last, n_rd_last;
    logic             w_accept;
    logic             w_all_issued;
    logic             w_move;

    assign o_in_ready   = (r_state == ST_IDLE);
    assign w_accept     = i_in_valid && o_in_ready;
    assign w_all_issued = (r_idx == r_count);
    assign w_move       = r_rd_vld && i_sts.out_free;
    assign o_raddr      = r_idx[IDX_W-1:0];

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_rd_vld  = 1'b0;
        n_rd_last = r_rd_last;
        o_cmd     = '0;
        o_cmd.wsel = WSEL_ITEM;
        o_waddr   = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    o_cmd.ld_item = 1'b1;
                    n_idx         = '0;
                    case (i_kind)
                        KIND_ADD:   n_state = ST_SCAN;
                        KIND_DRAIN: n_state = ST_DRAIN;
                        KIND_WHOLE: begin
                            o_cmd.wen  = 1'b1;
                            o_cmd.wsel = WSEL_WHOLE;
                            o_waddr    = '0;
                            n_count    = CNT_W'(1);
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                if (!w_all_issued) begin
                    o_cmd.ren = 1'b1;
                    n_idx     = r_idx + 1'b1;
                    n_rd_vld  = 1'b1;
                end
                if (r_rd_vld && i_sts.hit) begin
                    n_state  = ST_IDLE;
                    n_rd_vld = 1'b0;
                end else if (w_all_issued) begin
                    o_cmd.wen = 1'b1;
                    n_state   = ST_IDLE;
                    if (r_count == CNT_MAX) begin
                        o_cmd.wsel = WSEL_MERGE;
                        o_waddr    = LAST_IDX;
                    end else begin
                        o_cmd.wsel = WSEL_ITEM;
                        o_waddr    = r_count[IDX_W-1:0];
                        n_count    = r_count + 1'b1;
                    end
                end
            end
            ST_DRAIN: begin
                o_cmd.ld_out   = w_move;
                o_cmd.out_last = r_rd_last;
                n_rd_vld       = r_rd_vld && !w_move;
                if (!w_all_issued && (!r_rd_vld || w_move)) begin
                    o_cmd.ren = 1'b1;
                    n_idx     = r_idx + 1'b1;
                    n_rd_vld  = 1'b1;
                    n_rd_last = (CNT_W'(r_idx + 1'b1) == r_count);
                end
                if (w_all_issued && !r_rd_vld) begin
                    n_state = ST_IDLE;
                    n_count = '0;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_idx    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_idx    <= n_idx;
            r_rd_vld <= n_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_last <= n_rd_last;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("rectangle count above capacity");

    a_idle_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_rd_vld)
        else $error("read stage busy while idle");

    a_drain_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |=> (r_count == $past(r_count)) || (r_count == '0))
        else $error("count changed during drain");

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.wen |-> !o_cmd.ren && !o_cmd.ld_out)
        else $error("store written during a read pass");

    a_load_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.ld_out |-> r_rd_vld && (r_state == ST_DRAIN))
        else $error("output loaded without read data");

endmodule

`default_nettype wire

// ===== sv/dirty_rectangle_tracker.sv =====
// Add: one store read per entry, then the write; it ends early on a containing entry.
// Whole: the store is written in the cycle the item is accepted.
// Drain: each entry goes through the read stage and the output register, one beat
//   per cycle while the receiver keeps up.
// Flow: one item at a time, paced by the store read.
// Reset: synchronous, active low; clears list, pending beat and surface size, not the store.
`default_nettype none

module dirty_rectangle_tracker
    import drt_pkg::*;
#(
    parameter int MAX_RECTS = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    // Configuration writes
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [CFG_DATA_W-1:0] i_cfg_wdata,
    // Input items
    input  wire                  s_axis_tvalid,
    output logic                 s_axis_tready,
    input  wire [63:0]           s_axis_tdata,  // rect_left, rect_top, rect_right, rect_bottom
    input  wire [1:0]            s_axis_tuser,  // kind
    // Drained rectangles
    output logic                 m_axis_tvalid,
    input  wire                  m_axis_tready,
    output logic [63:0]          m_axis_tdata,  // out_left, out_top, out_right, out_bottom
    output logic                 m_axis_tlast   // last_of_run
);

    // Store index and count widths follow the list capacity
    localparam int IDX_W = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int CNT_W = $clog2(MAX_RECTS + 1);

    t_drt_cmd         w_cmd;
    t_drt_sts         w_sts;
    logic [IDX_W-1:0] w_raddr;
    logic [IDX_W-1:0] w_waddr;

    // Controller: sequence the containment scan, append/merge and drain passes
    drt_ctrl #(
        .MAX_RECTS (MAX_RECTS),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_kind     (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_raddr    (w_raddr),
        .o_waddr    (w_waddr)
    );

    // Datapath: hold the store, the item, the surface size and the output beat
    drt_dp #(
        .MAX_RECTS (MAX_RECTS),
        .IDX_W     (IDX_W)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (s_axis_tdata),
        .i_cmd       (w_cmd),
        .i_raddr     (w_raddr),
        .i_waddr     (w_waddr),
        .o_sts       (w_sts),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ===== test/tb_dirty_rectangle_tracker.sv =====
module tb_dirty_rectangle_tracker;
    timeunit 1ns;
    timeprecision 1ps;

    import drt_pkg::*;

    localparam int         CLK_PERIOD    = 12;
    localparam int         N_RECTS       = 16;
    // An add scans the list up to a containing entry and a drain moves one beat per
    // cycle while the receiver takes it; this wait covers anything still in flight once the last beat is out.
    localparam int         SETTLE_CYCLES = 40;
    localparam int         STALL_LIMIT   = 2000;
    localparam int         LONG_HOLD     = 400;
    localparam int         PHASE_ITEMS   = 36;
    // The fourth kind code is not decoded by the block.
    localparam logic [1:0] KIND_UNUSED   = 2'd3;

    // One drained rectangle as it leaves the block
    typedef struct packed {
        logic  last;
        t_rect rect;
    } t_drained_rect;

    // One row of the directed script; want is used only when typed is set
    typedef struct {
        logic [1:0]    kind;
        t_rect         rect;
        bit            typed;
        t_drained_rect want;
    } t_script_row;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [63:0]           s_axis_tdata  = '0;  // rect_left, rect_top, rect_right, rect_bottom
    logic [1:0]            s_axis_tuser  = '0;  // kind
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [63:0]           m_axis_tdata;        // out_left, out_top, out_right, out_bottom
    logic                  m_axis_tlast;        // last_of_run

    // Mirror of the block: list contents, fill level and surface size
    t_rect         dirty_list [N_RECTS];
    int            dirty_count = 0;
    logic [14:0]   surf_w      = '0;
    logic [14:0]   surf_h      = '0;
    // Rectangles that accepted drains still owe, oldest first
    t_drained_rect drain_due [$];

    t_script_row   script [$];

    bit run_on       = 1'b0;
    bit src_rush     = 1'b0;
    int hold_req     = 0;
    int quiet_cycles = 0;
    int mismatches   = 0;
    int rects_seen   = 0;
    int n_adds       = 0;
    int n_full_adds  = 0;
    int n_whole      = 0;
    int n_drains     = 0;
    int n_ignored    = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    dirty_rectangle_tracker #(
        .MAX_RECTS     (N_RECTS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // ------------------------------------------------------------------
    // List mirror
    // ------------------------------------------------------------------

    // Right or bottom edge at or before its opposite edge: no pixels covered
    function automatic bit is_empty_rect(input t_rect a);
        return ($signed(a.right) <= $signed(a.left)) ||
               ($signed(a.bottom) <= $signed(a.top));
    endfunction

    function automatic bit encloses(input t_rect s, input t_rect n);
        return ($signed(s.left) <= $signed(n.left)) && ($signed(n.right) <= $signed(s.right)) &&
               ($signed(s.top) <= $signed(n.top)) && ($signed(n.bottom) <= $signed(s.bottom));
    endfunction

    function automatic void add_to_list(input t_rect n);
        t_rect tail;
        bit    tail_empty;
        bit    n_empty;
        // Drop the add when any stored entry already covers it; empty ones too.
        for (int i = 0; i < dirty_count; i++) begin
            if (encloses(dirty_list[i], n)) return;
        end
        if (dirty_count < N_RECTS) begin
            dirty_list[dirty_count] = n;
            dirty_count++;
            return;
        end
        // Full list: fold the add into the last entry.
        n_full_adds++;
        tail       = dirty_list[N_RECTS-1];
        tail_empty = is_empty_rect(tail);
        n_empty    = is_empty_rect(n);
        if (tail_empty && !n_empty) begin
            tail = n;
        end else if (!tail_empty && !n_empty) begin
            if ($signed(n.left) < $signed(tail.left))       tail.left   = n.left;
            if ($signed(n.top) < $signed(tail.top))         tail.top    = n.top;
            if ($signed(n.right) > $signed(tail.right))     tail.right  = n.right;
            if ($signed(n.bottom) > $signed(tail.bottom))   tail.bottom = n.bottom;
        end
        dirty_list[N_RECTS-1] = tail;
    endfunction

    // Advance the mirror by one accepted item; queue whatever a drain owes.
    function automatic void update_dirty_list(input logic [1:0] kind, input t_rect r);
        t_drained_rect d;
        case (kind)
            KIND_ADD: begin
                add_to_list(r);
            end
            KIND_WHOLE: begin
                dirty_list[0].left   = '0;
                dirty_list[0].top    = '0;
                dirty_list[0].right  = {1'b0, surf_w};
                dirty_list[0].bottom = {1'b0, surf_h};
                dirty_count          = 1;
            end
            KIND_DRAIN: begin
                for (int i = 0; i < dirty_count; i++) begin
                    d.rect = dirty_list[i];
                    d.last = (i == dirty_count - 1);
                    drain_due.push_back(d);
                end
                dirty_count = 0;
            end
            default: begin
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Rectangle generators
    // ------------------------------------------------------------------

    function automatic t_rect mk_rect(input int l, input int t, input int r, input int b);
        mk_rect.left   = 16'(l);
        mk_rect.top    = 16'(t);
        mk_rect.right  = 16'(r);
        mk_rect.bottom = 16'(b);
    endfunction

    function automatic logic signed [15:0] near(input int lo, input int hi);
        return 16'(lo + int'($urandom_range(hi - lo)));
    endfunction

    function automatic logic signed [15:0] pick_edge();
        case ($urandom_range(4))
            0:       return 16'sh8000;
            1:       return 16'shFFFF;
            2:       return 16'sh0000;
            3:       return 16'sh0001;
            default: return 16'sh7FFF;
        endcase
    endfunction

    // Mix full-range noise with small coordinates, so that containment and
    // empty rectangles turn up often, and with copies of entries held now.
    function automatic t_rect make_rect();
        t_rect r;
        case ($urandom_range(9))
            0, 1: begin
                r = {$urandom(), $urandom()};
            end
            2, 3: begin
                r.left   = near(-8, 8);
                r.top    = near(-8, 8);
                r.right  = near(-8, 8);
                r.bottom = near(-8, 8);
            end
            4, 5, 6: begin
                r.left   = near(-40, 40);
                r.top    = near(-40, 40);
                r.right  = r.left + near(1, 12);
                r.bottom = r.top + near(1, 12);
            end
            7: begin
                r.left   = pick_edge();
                r.top    = pick_edge();
                r.right  = pick_edge();
                r.bottom = pick_edge();
            end
            default: begin
                if (dirty_count > 0) begin
                    r = dirty_list[$urandom_range(dirty_count - 1)];
                    if ($urandom_range(1) && ($signed(r.left) < $signed(r.right)))
                        r.left = r.left + 16'sd1;
                end else begin
                    r = mk_rect(0, 0, 4, 4);
                end
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Input side: all drive happens at the falling edge
    // ------------------------------------------------------------------

    // Offer one item, hold it until accepted, then update the mirror.
    // A typed row replaces the rectangles that this item owes with the one written down.
    task automatic offer(input logic [1:0] kind, input t_rect r,
                         input bit typed = 1'b0, input t_drained_rect want = '0);
        int gap;
        int owed;
        gap = src_rush ? 0 : $urandom_range(5);
        if (gap != 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = r;
        s_axis_tuser  = kind;
        do @(posedge i_clk); while (!s_axis_tready);
        owed = drain_due.size();
        update_dirty_list(kind, r);
        if (typed) begin
            while (drain_due.size() > owed) drain_due.pop_back();
            drain_due.push_back(want);
        end
        case (kind)
            KIND_ADD:   n_adds++;
            KIND_WHOLE: n_whole++;
            KIND_DRAIN: n_drains++;
            default:    n_ignored++;
        endcase
        @(negedge i_clk);
    endtask

    // Drop valid and wait for every owed rectangle to come out
    task automatic await_drained();
        s_axis_tvalid = 1'b0;
        while (drain_due.size() != 0) @(negedge i_clk);
    endtask

    // Let any add still scanning the list finish before touching registers
    task automatic settle_block();
        await_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [14:0] val);
        i_cfg_we    = 1'b1;
        i_cfg_idx   = idx;
        i_cfg_wdata = val;
        @(posedge i_clk);
        if (idx == CFG_SURF_W)
            surf_w = val;
        else
            surf_h = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------

    // Receiver: per cycle, either honor a long hold, sit out a drawn gap,
    // or raise ready. Every beat draws a fresh gap; runs of zero gaps come
    // and go so that some stretches take a beat every cycle.
    initial begin : drain_sink
        int gap_left;
        int hold_left;
        int taken;
        bit took;
        bit rush;
        gap_left  = 0;
        hold_left = 0;
        taken     = 0;
        rush      = 1'b0;
        forever begin
            @(posedge i_clk);
            took = i_rst_n && m_axis_tvalid && m_axis_tready;
            @(negedge i_clk);
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (took) begin
                taken++;
                if (taken % 24 == 0) rush = ($urandom_range(3) == 0);
                gap_left = rush ? 0 : $urandom_range(5);
            end
            if (hold_left != 0) begin
                hold_left--;
                m_axis_tready = 1'b0;
            end else if (gap_left != 0) begin
                gap_left--;
                m_axis_tready = 1'b0;
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    // Check every drained beat against the oldest owed rectangle
    always @(posedge i_clk) begin : drain_check
        t_drained_rect want;
        t_rect         got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            rects_seen++;
            if (drain_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("beat %0d: unexpected l=%0d t=%0d r=%0d b=%0d last=%0b",
                             rects_seen, got.left, got.top, got.right, got.bottom,
                             m_axis_tlast);
            end else begin
                want = drain_due.pop_front();
                if (got.left !== want.rect.left || got.top !== want.rect.top ||
                    got.right !== want.rect.right || got.bottom !== want.rect.bottom ||
                    m_axis_tlast !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"beat %0d: expected l=%0d t=%0d r=%0d b=%0d last=%0b, ",
                                  "got l=%0d t=%0d r=%0d b=%0d last=%0b"},
                                 rects_seen, want.rect.left, want.rect.top,
                                 want.rect.right, want.rect.bottom, want.last,
                                 got.left, got.top, got.right, got.bottom, m_axis_tlast);
                end
            end
        end
    end

    // Watchdog: end the run when no beat moves on either side for too long
    always @(posedge i_clk) begin
        if (!run_on || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("no beat moved for %0d cycles, %0d rectangles still owed",
                     STALL_LIMIT, drain_due.size());
            $display("dirty_rectangle_tracker: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial begin : stimulus
        int          sent;
        int          n_add;
        int          pick;
        bit          paused;
        logic [1:0]  kind;
        logic [14:0] cfg_w;
        logic [14:0] cfg_h;

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        run_on  = 1'b1;

        // Directed script; surface registers still hold their reset value of zero.
        // Drain an empty list: no beats.
        script.push_back('{KIND_DRAIN, mk_rect(0, 0, 0, 0), 1'b0, '0});
        // Store the full-range rectangle, then an empty one that it covers.
        script.push_back('{KIND_ADD, mk_rect(-32768, -32768, 32767, 32767), 1'b0, '0});
        script.push_back('{KIND_ADD, mk_rect(5, 5, 5, 5), 1'b0, '0});
        // Unused kind: ignored.
        script.push_back('{KIND_UNUSED, mk_rect(32767, -32768, -1, 0), 1'b0, '0});
        script.push_back('{KIND_DRAIN, mk_rect(0, 0, 0, 0), 1'b1,
                           '{last: 1'b1, rect: mk_rect(-32768, -32768, 32767, 32767)}});
        // Whole surface at zero size.
        script.push_back('{KIND_WHOLE, mk_rect(0, 0, 0, 0), 1'b0, '0});
        script.push_back('{KIND_DRAIN, mk_rect(0, 0, 0, 0), 1'b1,
                           '{last: 1'b1, rect: mk_rect(0, 0, 0, 0)}});
        // Fill the list: whole entry, fourteen thin strips, then an empty tail.
        script.push_back('{KIND_WHOLE, mk_rect(0, 0, 0, 0), 1'b0, '0});
        for (int i = 1; i <= 14; i++)
            script.push_back('{KIND_ADD, mk_rect(i, 0, i + 1, 1), 1'b0, '0});
        script.push_back('{KIND_ADD, mk_rect(100, 100, 50, 50), 1'b0, '0});
        // Full list: empty onto empty, real onto empty, empty onto real, real onto real.
        script.push_back('{KIND_ADD, mk_rect(200, 200, 100, 100), 1'b0, '0});
        script.push_back('{KIND_ADD, mk_rect(-5, -5, 3, 3), 1'b0, '0});
        script.push_back('{KIND_ADD, mk_rect(300, 300, 299, 299), 1'b0, '0});
        script.push_back('{KIND_ADD, mk_rect(10, -20, 20, -10), 1'b0, '0});
        script.push_back('{KIND_DRAIN, mk_rect(0, 0, 0, 0), 1'b0, '0});
        foreach (script[i])
            offer(script[i].kind, script[i].rect, script[i].typed, script[i].want);

        // Random phases, each under its own surface size
        for (int ph = 0; ph < 4; ph++) begin
            settle_block();
            case (ph)
                0: begin
                    cfg_w = 15'h7FFF;
                    cfg_h = 15'h7FFF;
                end
                1: begin
                    cfg_w = 15'd0;
                    cfg_h = 15'h7FFF;
                end
                2: begin
                    cfg_w = 15'($urandom_range(32767));
                    cfg_h = 15'($urandom_range(32767));
                end
                default: begin
                    cfg_w = 15'h7FFF;
                    cfg_h = 15'd1;
                end
            endcase
            write_reg(CFG_SURF_W, cfg_w);
            write_reg(CFG_SURF_H, cfg_h);

            if (ph == 1) begin
                // Back-pressure: hold the receiver off while a full drain and a
                // few more items queue up, so the block stalls its input.
                hold_req = LONG_HOLD;
                src_rush = 1'b1;
                for (int i = 0; i < N_RECTS; i++)
                    offer(KIND_ADD, mk_rect(4 * i, -3, 4 * i + 3, 7));
                offer(KIND_DRAIN, make_rect());
                offer(KIND_WHOLE, make_rect());
                offer(KIND_DRAIN, make_rect());
                repeat (3) offer(KIND_ADD, make_rect());
                offer(KIND_DRAIN, make_rect());
                src_rush = 1'b0;
            end

            sent   = 0;
            paused = 1'b0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(5) == 0) src_rush = !src_rush;
                pick = $urandom_range(9);
                if (pick <= 5) begin
                    // Well-formed run: optional whole, a batch of adds, a drain.
                    // A third of the batches run to 14 to 22 adds, near or past the list capacity.
                    if ($urandom_range(3) == 0) begin
                        offer(KIND_WHOLE, make_rect());
                        sent++;
                    end
                    n_add = ($urandom_range(2) == 0) ? $urandom_range(22, 14)
                                                      : $urandom_range(8);
                    repeat (n_add) begin
                        offer(KIND_ADD, make_rect());
                        sent++;
                    end
                    offer(KIND_DRAIN, make_rect());
                    sent++;
                end else if (pick == 6) begin
                    // Noise: any kind, unused code included
                    kind = 2'($urandom_range(3));
                    offer(kind, make_rect());
                    if (kind != KIND_UNUSED) sent++;
                end else if (pick == 7) begin
                    // Broken run: adds with no drain behind them
                    repeat ($urandom_range(4, 1)) begin
                        offer(KIND_ADD, make_rect());
                        sent++;
                    end
                end else if (pick == 8) begin
                    offer(KIND_WHOLE, make_rect());
                    offer(KIND_DRAIN, make_rect());
                    sent += 2;
                end else begin
                    offer(KIND_DRAIN, make_rect());
                    sent++;
                end
                // Halfway through, pause the sender until the output is clear
                if (!paused && sent >= PHASE_ITEMS / 2) begin
                    await_drained();
                    paused = 1'b1;
                end
            end
        end

        settle_block();
        $display("covered %0d adds (%0d folded into a full list), %0d whole marks, %0d drains,",
                 n_adds, n_full_adds, n_whole, n_drains);
        $display("  %0d ignored items, %0d drained rectangles checked, %0d mismatches",
                 n_ignored, rects_seen, mismatches);
        if (mismatches == 0)
            $display("dirty_rectangle_tracker: match");
        else
            $display("dirty_rectangle_tracker: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/drt_pkg.sv
sv/drt_dp.sv
sv/drt_ctrl.sv
sv/dirty_rectangle_tracker.sv
test/tb_dirty_rectangle_tracker.sv
